// ----- sv/binary_projection_profile_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the projection profile block
// Clock is clk, synchronous reset is rst in every user of these macros.
// ----------------------------------------------------------------------------
`ifndef BINARY_PROJECTION_PROFILE_MACROS_SVH
`define BINARY_PROJECTION_PROFILE_MACROS_SVH

// Same-cycle implication.
`define BPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bpp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared types, constants and helpers of the projection profile block.
// ----------------------------------------------------------------------------
package bpp_pkg;

  localparam int CFG_W   = 11;   // frame size registers and tallies
  localparam int IDX_W   = 10;   // row / column positions
  localparam int PIX_W   = 8;
  localparam int MAX_ROWS = 1024;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  localparam logic [CFG_W-1:0] TALLY_MAX = '1;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  // register indexes (paddr[2])
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // result kinds
  localparam logic KIND_ROW = 1'b0;
  localparam logic KIND_COL = 1'b1;

  // one queue entry: the results caused by one pixel
  typedef struct packed {
    logic             has_col;   // pixel in last row
    logic             has_row;   // pixel in last column
    logic [IDX_W-1:0] col_index;
    logic [CFG_W-1:0] col_total;
    logic [IDX_W-1:0] row_index;
    logic [CFG_W-1:0] row_total;
  } entry_t;

  function automatic logic [CFG_W-1:0] sat_inc(input logic [CFG_W-1:0] tally,
                                               input logic inc);
    logic [CFG_W-1:0] res;
    res = tally;
    if (inc && (tally != TALLY_MAX)) begin
      res = tally + CFG_W'(1);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- sv/binary_projection_profile.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A pixel's results pass through the stage 2 register and the queue into the output register.
// Throughput: one pixel per cycle unless stage 2 waits on a full queue; the column
//   store is read on transfer and written as the pixel leaves stage 2, with a bypass
//   for back-to-back hits on one entry. A two-result pixel holds the output for both.
// Reset: synchronous; clears counters, tallies, queue and output valid;
//   frame_width = 640, frame_height = 480. The column store needs no clearing.
// ----------------------------------------------------------------------------
// binary_projection_profile
// Row and column projection profile of a binary mask image streamed in raster
// order. Intake (bpp_front) tracks the position, tallies each row and keeps a
// column tally store; a 4-entry queue (bpp_queue) holds pixels that produce
// results; the sequencer (bpp_back) emits them, column result first.
// Row count comes out at each row end; column totals come out along the last
// row. Frame size registers sit on an APB-style port: width at 0x0, height
// at 0x4.
// ----------------------------------------------------------------------------
`include "binary_projection_profile_macros.svh"

module binary_projection_profile #(
  parameter int MAX_COLUMNS = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // configuration
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // pixel input
  input  wire logic [bpp_pkg::PIX_W-1:0] pixel,
  input  wire logic                      pixel_valid,
  output logic                           pixel_ready,
  // result output
  output logic                           result_valid,
  input  wire logic                      result_ready,
  output logic                           result_kind,
  output logic [bpp_pkg::IDX_W-1:0]      line_index,
  output logic [bpp_pkg::CFG_W-1:0]      set_pixel_total,
  output logic                           last_of_item,
  output logic                           frame_done
);

  logic [bpp_pkg::CFG_W-1:0] frame_width;
  logic [bpp_pkg::CFG_W-1:0] frame_height;
  logic                      cfg_write;

  logic                      q_full;
  logic                      q_push;
  logic                      q_pop;
  logic                      q_not_empty;
  bpp_pkg::entry_t           q_in;
  bpp_pkg::entry_t           q_head;

  // --------------------------------------------------------------------------
  // Configuration registers. Word select is paddr[2]; only the low 11 bits of
  // a write are kept. No wait states.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bpp_pkg::WIDTH_RESET;
      frame_height <= bpp_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        bpp_pkg::REG_WIDTH:  frame_width  <= pwdata[bpp_pkg::CFG_W-1:0];
        bpp_pkg::REG_HEIGHT: frame_height <= pwdata[bpp_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bpp_pkg::REG_WIDTH:  prdata = 32'(frame_width);
      bpp_pkg::REG_HEIGHT: prdata = 32'(frame_height);
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Intake: positions, row tally, column store. Only pixels in the last row
  // or last column push an entry; the rest just update the store.
  // --------------------------------------------------------------------------
  bpp_front #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .pixel        (pixel),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_in)
  );

  // decouples intake from output backpressure
  bpp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // result sequencing and output register
  bpp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result_kind     (result_kind),
    .line_index      (line_index),
    .set_pixel_total (set_pixel_total),
    .last_of_item    (last_of_item),
    .frame_done      (frame_done)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BPP_ASSERT_NOW(a_no_overflow, q_push, !q_full, "queue push while full")
  `BPP_ASSERT_NOW(a_done_on_row, result_valid && frame_done,
                  (result_kind == bpp_pkg::KIND_ROW) && last_of_item,
                  "frame_done on a result that is not the final row result")
  `BPP_ASSERT_NEXT(a_row_follows_col,
                   result_valid && result_ready &&
                   (result_kind == bpp_pkg::KIND_COL) && !last_of_item,
                   result_valid && (result_kind == bpp_pkg::KIND_ROW) && frame_done,
                   "final column result not followed by frame row result")

endmodule
`default_nettype wire

// ----- sv/bpp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpp_front
// Pixel intake: position tracking, row tally and the column tally store
// (read in the accept cycle, updated as the pixel leaves stage 2, with a bypass).
// ----------------------------------------------------------------------------
module bpp_front #(
  parameter int MAX_COLUMNS = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [bpp_pkg::CFG_W-1:0] frame_width,
  input  wire logic [bpp_pkg::CFG_W-1:0] frame_height,
  input  wire logic [bpp_pkg::PIX_W-1:0] pixel,
  input  wire logic                      pixel_valid,
  output logic                           pixel_ready,
  input  wire logic                      q_full,
  output logic                           q_push,
  output bpp_pkg::entry_t                q_entry
);

  localparam int SLOT_W = $clog2(MAX_COLUMNS);

  logic [bpp_pkg::IDX_W-1:0] column_position;
  logic [bpp_pkg::IDX_W-1:0] row_position;
  logic [bpp_pkg::CFG_W-1:0] row_tally;

  logic [bpp_pkg::CFG_W-1:0] col_tally_mem [MAX_COLUMNS];
  logic [bpp_pkg::CFG_W-1:0] rd_data;

  // stage 2 holding register
  logic                      s2_valid;
  logic                      s2_bit;
  logic                      s2_first;
  logic [SLOT_W-1:0]         s2_slot;
  logic                      s2_has_col;
  logic                      s2_has_row;
  logic [bpp_pkg::IDX_W-1:0] s2_col;
  logic [bpp_pkg::IDX_W-1:0] s2_row;
  logic [bpp_pkg::CFG_W-1:0] s2_row_total;

  logic [bpp_pkg::CFG_W-1:0] w_eff;
  logic [bpp_pkg::CFG_W-1:0] h_eff;
  logic                      last_col;
  logic                      last_row;
  logic                      set_bit;
  logic [SLOT_W-1:0]         slot;
  logic [bpp_pkg::CFG_W-1:0] r_total;
  logic [bpp_pkg::CFG_W-1:0] col_total;
  logic                      accept;
  logic                      s2_go;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = bpp_pkg::CFG_W'(1);
    end else if (32'(frame_width) > MAX_COLUMNS) begin
      w_eff = bpp_pkg::CFG_W'(MAX_COLUMNS);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = bpp_pkg::CFG_W'(1);
    end else if (32'(frame_height) > bpp_pkg::MAX_ROWS) begin
      h_eff = bpp_pkg::CFG_W'(bpp_pkg::MAX_ROWS);
    end else begin
      h_eff = frame_height;
    end
  end

  assign last_col = {1'b0, column_position} >= (w_eff - bpp_pkg::CFG_W'(1));
  assign last_row = {1'b0, row_position} >= (h_eff - bpp_pkg::CFG_W'(1));
  assign set_bit  = (pixel != '0);
  assign slot     = (32'(column_position) < MAX_COLUMNS) ? SLOT_W'(column_position)
                                                         : SLOT_W'(MAX_COLUMNS - 1);
  assign r_total  = bpp_pkg::sat_inc(row_tally, set_bit);

  // first row overwrites the store, later rows accumulate
  assign col_total = s2_first ? bpp_pkg::CFG_W'(s2_bit) : bpp_pkg::sat_inc(rd_data, s2_bit);

  assign q_push      = s2_valid && (s2_has_col || s2_has_row) && !q_full;
  assign s2_go       = s2_valid && (!(s2_has_col || s2_has_row) || !q_full);
  assign pixel_ready = !s2_valid || s2_go;
  assign accept      = pixel_valid && pixel_ready;

  always_comb begin
    q_entry.has_col   = s2_has_col;
    q_entry.has_row   = s2_has_row;
    q_entry.col_index = s2_col;
    q_entry.col_total = col_total;
    q_entry.row_index = s2_row;
    q_entry.row_total = s2_row_total;
  end

  // position counters and row tally
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      row_tally       <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_position <= '0;
        row_tally       <= '0;
        row_position    <= last_row ? '0 : row_position + bpp_pkg::IDX_W'(1);
      end else begin
        column_position <= column_position + bpp_pkg::IDX_W'(1);
        row_tally       <= r_total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (accept) begin
      s2_valid <= 1'b1;
    end else if (s2_go) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_bit       <= set_bit;
      s2_first     <= (row_position == '0);
      s2_slot      <= slot;
      s2_has_col   <= last_row;
      s2_has_row   <= last_col;
      s2_col       <= column_position;
      s2_row       <= row_position;
      s2_row_total <= r_total;
    end
  end

  // column store: write on stage 2 exit, read on accept; bypass when the
  // leaving pixel updates the entry being read (one-pixel-wide frames)
  always_ff @(posedge clk) begin
    if (s2_go) begin
      col_tally_mem[s2_slot] <= col_total;
    end
    if (accept) begin
      if (s2_go && (s2_slot == slot)) begin
        rd_data <= col_total;
      end else begin
        rd_data <= col_tally_mem[slot];
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/bpp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpp_queue
// Short FIFO of pending result entries between intake and output.
// ----------------------------------------------------------------------------
module bpp_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire bpp_pkg::entry_t push_entry,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output bpp_pkg::entry_t      head
);

  bpp_pkg::entry_t             slots [bpp_pkg::Q_DEPTH];
  logic [bpp_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [bpp_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [bpp_pkg::Q_PTR_W:0]   count;

  assign full      = (count == (bpp_pkg::Q_PTR_W + 1)'(bpp_pkg::Q_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + bpp_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + bpp_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (bpp_pkg::Q_PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (bpp_pkg::Q_PTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ----- sv/bpp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpp_back
// Result sequencer: pops entries, emits column result before row result,
// output register toward the consumer.
// ----------------------------------------------------------------------------
module bpp_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      q_not_empty,
  input  wire bpp_pkg::entry_t           q_head,
  output logic                           q_pop,
  output logic                           result_valid,
  input  wire logic                      result_ready,
  output logic                           result_kind,
  output logic [bpp_pkg::IDX_W-1:0]      line_index,
  output logic [bpp_pkg::CFG_W-1:0]      set_pixel_total,
  output logic                           last_of_item,
  output logic                           frame_done
);

  logic                      pend;        // row result still owed
  logic [bpp_pkg::IDX_W-1:0] pend_index;
  logic [bpp_pkg::CFG_W-1:0] pend_total;
  logic                      pend_done;
  logic                      load_en;

  assign load_en = !result_valid || result_ready;
  assign q_pop   = load_en && !pend && q_not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend         <= 1'b0;
    end else if (load_en) begin
      if (pend) begin
        result_valid <= 1'b1;
        pend         <= 1'b0;
      end else if (q_not_empty) begin
        result_valid <= 1'b1;
        pend         <= q_head.has_col && q_head.has_row;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      if (pend) begin
        result_kind     <= bpp_pkg::KIND_ROW;
        line_index      <= pend_index;
        set_pixel_total <= pend_total;
        last_of_item    <= 1'b1;
        frame_done      <= pend_done;
      end else if (q_not_empty) begin
        pend_index <= q_head.row_index;
        pend_total <= q_head.row_total;
        pend_done  <= q_head.has_col;
        if (q_head.has_col) begin
          result_kind     <= bpp_pkg::KIND_COL;
          line_index      <= q_head.col_index;
          set_pixel_total <= q_head.col_total;
          last_of_item    <= !q_head.has_row;
          frame_done      <= 1'b0;
        end else begin
          result_kind     <= bpp_pkg::KIND_ROW;
          line_index      <= q_head.row_index;
          set_pixel_total <= q_head.row_total;
          last_of_item    <= 1'b1;
          frame_done      <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb_binary_projection_profile.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_projection_profile
// Self-checking bench for the row/column projection profile block. Mask
// frames stream in raster order over a valid/ready port. Frame sizes are
// set over the APB port and read back. A scoreboard class tracks position,
// row tally and column store, and predicts every row and column count.
// Counts are compared in order as they transfer out.
// ----------------------------------------------------------------------------
module tb_binary_projection_profile;

  localparam int STORE_COLUMNS = 1024;  // column store depth of the instance
  localparam int SETTLE_CYCLES = 8;     // margin for pixels that cause no count to drain
  localparam int QUIET_LIMIT   = 3000;  // cycles with no transfer at all

  // One count as it leaves the block.
  typedef struct packed {
    logic                      kind;
    logic [bpp_pkg::IDX_W-1:0] line;
    logic [bpp_pkg::CFG_W-1:0] total;
    logic                      last;
    logic                      done;
  } count_t;

  // --------------------------------------------------------------------------
  // Scoreboard: a private copy of frame size, position, row tally and column
  // store. take_pixel() is called on every pixel transfer and queues the
  // counts that pixel causes; check_count() is called on every count
  // transfer and compares against the oldest queued count.
  // --------------------------------------------------------------------------
  class projection_tracker;
    logic [bpp_pkg::CFG_W-1:0] width_setting;
    logic [bpp_pkg::CFG_W-1:0] height_setting;
    int               col_pos;
    int               row_pos;
    int               row_tally;
    int               col_tally [STORE_COLUMNS];
    count_t           pending_counts [$];
    int               errors;
    int               reported;

    function new();
      width_setting  = bpp_pkg::WIDTH_RESET;
      height_setting = bpp_pkg::HEIGHT_RESET;
      col_pos   = 0;
      row_pos   = 0;
      row_tally = 0;
      errors    = 0;
      reported  = 0;
      foreach (col_tally[i]) col_tally[i] = 0;
    endfunction

    // Effective size: zero acts as one, anything past the limit saturates.
    function int span(input logic [bpp_pkg::CFG_W-1:0] size_val, input int limit);
      if (size_val == 0) return 1;
      if (int'(size_val) > limit) return limit;
      return int'(size_val);
    endfunction

    function int frame_cols();
      return span(width_setting, STORE_COLUMNS);
    endfunction

    function int frame_rows();
      return span(height_setting, bpp_pkg::MAX_ROWS);
    endfunction

    function bit at_frame_start();
      return (col_pos == 0) && (row_pos == 0);
    endfunction

    function void set_size(input logic reg_index,
                           input logic [bpp_pkg::CFG_W-1:0] size_val);
      if (reg_index == bpp_pkg::REG_WIDTH) width_setting = size_val;
      else height_setting = size_val;
    endfunction

    function int tally_add(input int tally, input int hit);
      int sum;
      sum = tally + hit;
      if (sum > int'(bpp_pkg::TALLY_MAX)) sum = int'(bpp_pkg::TALLY_MAX);
      return sum;
    endfunction

    function void push_count(input logic kind, input int line, input int total,
                             input logic last, input logic done);
      count_t c;
      c.kind  = kind;
      c.line  = bpp_pkg::IDX_W'(line);
      c.total = bpp_pkg::CFG_W'(total);
      c.last  = last;
      c.done  = done;
      pending_counts.push_back(c);
    endfunction

    function void take_pixel(input logic [bpp_pkg::PIX_W-1:0] px);
      int cols;
      int rows;
      int hit;
      int col_sum;
      int row_sum;
      bit end_col;
      bit end_row;
      cols    = frame_cols();
      rows    = frame_rows();
      hit     = (px != 0) ? 1 : 0;
      // positions past the end (size shrunk mid-frame) count as the end
      end_col = col_pos >= cols - 1;
      end_row = row_pos >= rows - 1;
      // first row overwrites the store, so no clearing between frames
      col_sum = (row_pos == 0) ? hit : tally_add(col_tally[col_pos], hit);
      col_tally[col_pos] = col_sum;
      row_sum = tally_add(row_tally, hit);
      // column count goes out first on the frame's final pixel
      if (end_row) push_count(bpp_pkg::KIND_COL, col_pos, col_sum, !end_col, 1'b0);
      if (end_col) begin
        push_count(bpp_pkg::KIND_ROW, row_pos, row_sum, 1'b1, end_row);
        row_tally = 0;
        col_pos   = 0;
        row_pos   = end_row ? 0 : (row_pos + 1) % (1 << bpp_pkg::IDX_W);
      end else begin
        row_tally = row_sum;
        col_pos   = (col_pos + 1) % STORE_COLUMNS;
      end
    endfunction

    function void mismatch(input string msg);
      errors++;
      if (reported < 10) begin
        reported++;
        $display("%0t: %s", $time, msg);
      end
    endfunction

    function void check_count(input logic kind, input logic [bpp_pkg::IDX_W-1:0] line,
                              input logic [bpp_pkg::CFG_W-1:0] total, input logic last,
                              input logic done);
      count_t want;
      if (pending_counts.size() == 0) begin
        mismatch($sformatf("unexpected count: kind %0d line %0d total %0d last %0d done %0d",
                           kind, line, total, last, done));
        return;
      end
      want = pending_counts.pop_front();
      if (kind !== want.kind || line !== want.line || total !== want.total ||
          last !== want.last || done !== want.done)
        mismatch($sformatf({"count mismatch: want kind %0d line %0d total %0d last %0d ",
                            "done %0d, got kind %0d line %0d total %0d last %0d done %0d"},
                           want.kind, want.line, want.total, want.last, want.done,
                           kind, line, total, last, done));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT hookup. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [2:0]                paddr = '0;
  logic [31:0]               pwdata = '0;
  logic [31:0]               prdata;
  logic                      pready;
  logic [bpp_pkg::PIX_W-1:0] pixel = '0;
  logic                      pixel_valid = 1'b0;
  logic                      pixel_ready;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  logic                      result_kind;
  logic [bpp_pkg::IDX_W-1:0] line_index;
  logic [bpp_pkg::CFG_W-1:0] set_pixel_total;
  logic                      last_of_item;
  logic                      frame_done;

  projection_tracker tracker;
  int                send_idle_pct = 38;  // chance per slot that the pixel side holds off
  int                recv_idle_pct = 78;  // chance per cycle that the count side stalls
  int                pixels_sent = 0;
  int                quiet_cycles = 0;

  always #6 clk = ~clk;

  binary_projection_profile #(
    .MAX_COLUMNS(STORE_COLUMNS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .pixel(pixel),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_kind(result_kind),
    .line_index(line_index),
    .set_pixel_total(set_pixel_total),
    .last_of_item(last_of_item),
    .frame_done(frame_done)
  );

  // --------------------------------------------------------------------------
  // Count side: check every transfer, then pick the next ready at random.
  // Outputs are sampled at the edge, before the DUT's updates land.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready)
        tracker.check_count(result_kind, line_index, set_pixel_total, last_of_item,
                            frame_done);
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: any transfer or APB activity restarts the count.
  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (result_valid && result_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_binary_projection_profile: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. All tasks are entered just after a rising edge and drive with
  // nonblocking assignments, so each signal gets one update per edge.
  // --------------------------------------------------------------------------

  // One pixel transfer, with random hold-off before valid goes up.
  task automatic send_pixel(input logic [bpp_pkg::PIX_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= value;
    do @(posedge clk); while (!pixel_ready);
    tracker.take_pixel(value);
    pixels_sent++;
  endtask

  // Stop sending, wait for every predicted count, then let the pipe empty
  // of pixels that cause no count.
  task automatic wait_idle();
    pixel_valid <= 1'b0;
    while (tracker.pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write then read-back of the same register; psel stays up between,
  // then psel goes low before the next access.
  // Upper data bits are junk: only the low 11 bits belong to the register.
  task automatic set_reg(input logic reg_index, input logic [bpp_pkg::CFG_W-1:0] size_val);
    logic [31:0] word;
    word = $urandom();
    word[bpp_pkg::CFG_W-1:0] = size_val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_size(reg_index, size_val);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(size_val))
      tracker.mismatch($sformatf("register %0d read back 0x%0h, want 0x%0h",
                                 reg_index, prdata, size_val));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Mask value: zero, or any nonzero byte with the given chance in percent.
  function automatic logic [bpp_pkg::PIX_W-1:0] pick_pixel(input int density);
    if ($urandom_range(99) >= density) return '0;
    return bpp_pkg::PIX_W'($urandom_range(255, 1));
  endfunction

  // Frame size register: mostly small, sometimes zero (acts as one).
  function automatic logic [bpp_pkg::CFG_W-1:0] pick_size(input int top);
    if ($urandom_range(99) < 8) return '0;
    return bpp_pkg::CFG_W'($urandom_range(top, 1));
  endfunction

  function automatic int pick_density();
    case ($urandom_range(4))
      0: return 0;
      1: return 25;
      2: return 50;
      3: return 85;
      default: return 100;
    endcase
  endfunction

  // Directed frames: byte extremes, zero sizes, oversized sizes and
  // shrinking width and height in mid-frame.
  task automatic directed_frames();
    // 3x2 frame: row counts, then column counts along the last row
    set_reg(bpp_pkg::REG_WIDTH, 11'd3);
    set_reg(bpp_pkg::REG_HEIGHT, 11'd2);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd1);
    send_pixel(8'd128);
    send_pixel(8'd0);
    send_pixel(8'd127);
    // zero width and height: 1x1 frames, two counts per pixel
    wait_idle();
    set_reg(bpp_pkg::REG_WIDTH, 11'd0);
    set_reg(bpp_pkg::REG_HEIGHT, 11'd0);
    send_pixel(8'd255);
    send_pixel(8'd0);
    // width past the store saturates; single row, so every pixel gives a
    // column count; then shrink width so the current column ends the row
    wait_idle();
    set_reg(bpp_pkg::REG_WIDTH, 11'd2047);
    set_reg(bpp_pkg::REG_HEIGHT, 11'd1);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd64);
    send_pixel(8'd32);
    send_pixel(8'd1);
    wait_idle();
    set_reg(bpp_pkg::REG_WIDTH, 11'd2);
    send_pixel(8'd200);
    // oversized height, then shrink it below the current row
    wait_idle();
    set_reg(bpp_pkg::REG_HEIGHT, 11'd2047);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd7);
    send_pixel(8'd9);
    send_pixel(8'd0);
    wait_idle();
    set_reg(bpp_pkg::REG_HEIGHT, 11'd3);
    send_pixel(8'd3);
    send_pixel(8'd0);
  endtask

  // Random small frames until about n_pixels have gone in. A quarter of the
  // frames pause part way, drain, and change size before finishing. Width
  // only grows mid-frame on row 0, so no column entry is read unwritten.
  task automatic random_frames(input int n_pixels);
    int                        stop_at;
    int                        cols;
    int                        cut;
    int                        density;
    logic [bpp_pkg::CFG_W-1:0] new_width;
    stop_at = pixels_sent + n_pixels;
    while (pixels_sent < stop_at) begin
      wait_idle();
      set_reg(bpp_pkg::REG_WIDTH, pick_size(12));
      set_reg(bpp_pkg::REG_HEIGHT, pick_size(6));
      density = pick_density();
      cols    = tracker.frame_cols();
      cut     = 0;
      if ($urandom_range(3) == 0 && cols * tracker.frame_rows() > 1)
        cut = $urandom_range(cols * tracker.frame_rows() - 1, 1);
      if (cut != 0) begin
        repeat (cut) send_pixel(pick_pixel(density));
        wait_idle();
        new_width = pick_size(12);
        if (tracker.row_pos != 0 && tracker.span(new_width, STORE_COLUMNS) > cols)
          new_width = bpp_pkg::CFG_W'(cols);
        set_reg(bpp_pkg::REG_WIDTH, new_width);
        set_reg(bpp_pkg::REG_HEIGHT, pick_size(6));
      end
      do send_pixel(pick_pixel(density)); while (!tracker.at_frame_start());
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence: directed frames, then random frames under three idle
  // patterns. The last pattern starts with one full-width row so the
  // column position runs through every index.
  // --------------------------------------------------------------------------
  initial begin
    tracker = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_frames();
    random_frames(250);

    wait_idle();
    send_idle_pct = 78;
    recv_idle_pct = 38;
    random_frames(250);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_reg(bpp_pkg::REG_WIDTH, 11'd1024);
    set_reg(bpp_pkg::REG_HEIGHT, 11'd1);
    repeat (STORE_COLUMNS) send_pixel(pick_pixel(50));
    random_frames(100);

    // drain, then wait the settle margin so a stray count would still show up
    wait_idle();
    if (tracker.errors == 0 && tracker.pending_counts.size() == 0)
      $display("tb_binary_projection_profile: clean");
    else
      $display("tb_binary_projection_profile: errors");
    $finish;
  end

endmodule
